### hw/rtl/assert_macros.svh
// assertion macros used by bdaf_serial
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

### hw/rtl/bdaf_pkg.sv
// types and constants of the decimal ascii formatter
package bdaf_pkg;

  typedef enum logic [1:0] {
    FUNC_U8  = 2'd0,
    FUNC_U16 = 2'd1,
    FUNC_S8  = 2'd2,
    FUNC_S16 = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] value_bits;
  } in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_t;

  // magnitude and its hundreds quotient
  typedef struct packed {
    logic [1:0]  func;
    logic        neg;
    logic [15:0] mag;
    logic [9:0]  hi;
  } split_t;

  // ten-thousands digit, middle pair and low pair
  typedef struct packed {
    logic [1:0] func;
    logic       neg;
    logic [2:0] hh;
    logic [6:0] hl;
    logic [6:0] lo;
  } dig_t;

endpackage

### hw/rtl/bdaf_split.sv
// input register, magnitude and division by one hundred
module bdaf_split (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  bdaf_pkg::in_t    data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output bdaf_pkg::split_t data_o
);

  // 2^24 / 100 rounded up, exact for every 16-bit magnitude
  localparam logic [33:0] Recip100 = 34'd167773;

  logic          valid_q;
  bdaf_pkg::in_t in_q;
  logic          is_signed;
  logic          wide;
  logic          neg;
  logic [7:0]    low_byte;
  logic [15:0]   mag;
  logic [33:0]   prod;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      in_q <= data_i;
    end
  end

  always_comb begin
    is_signed = (in_q.func == bdaf_pkg::FUNC_S8) || (in_q.func == bdaf_pkg::FUNC_S16);
    wide      = (in_q.func == bdaf_pkg::FUNC_U16) || (in_q.func == bdaf_pkg::FUNC_S16);
    low_byte  = in_q.value_bits[7:0];
    if (wide) begin
      neg = is_signed && in_q.value_bits[15];
      mag = neg ? 16'(~in_q.value_bits + 16'd1) : in_q.value_bits;
    end else begin
      neg = is_signed && low_byte[7];
      mag = neg ? {8'd0, 8'(~low_byte + 8'd1)} : {8'd0, low_byte};
    end
    prod = 34'(mag) * Recip100;
  end

  assign valid_o     = valid_q;
  assign data_o.func = in_q.func;
  assign data_o.neg  = neg;
  assign data_o.mag  = mag;
  assign data_o.hi   = prod[33:24];

endmodule

### hw/rtl/bdaf_hundreds.sv
// register stage that splits the magnitude into digit pairs
module bdaf_hundreds (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  bdaf_pkg::split_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output bdaf_pkg::dig_t   data_o
);

  localparam logic [15:0] Hundred  = 16'd100;
  // 2^12 / 100 rounded up, exact below 656
  localparam logic [15:0] Recip100 = 16'd41;

  logic             valid_q;
  bdaf_pkg::split_t split_q;
  logic [15:0]      hi_x100;
  logic [15:0]      hprod;
  logic [2:0]       hh;
  logic [9:0]       hh_x100;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      split_q <= data_i;
    end
  end

  always_comb begin
    hi_x100 = 16'(split_q.hi) * Hundred;
    hprod   = 16'(split_q.hi) * Recip100;
    hh      = hprod[14:12];
    hh_x100 = 10'(10'(hh) * 10'(Hundred));
  end

  assign valid_o     = valid_q;
  assign data_o.func = split_q.func;
  assign data_o.neg  = split_q.neg;
  assign data_o.hh   = hh;
  assign data_o.hl   = 7'(split_q.hi - hh_x100);
  assign data_o.lo   = 7'(split_q.mag - hi_x100);

endmodule

### hw/rtl/bdaf_serial.sv
// field assembly and character serialiser
`include "assert_macros.svh"

module bdaf_serial (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  bdaf_pkg::dig_t data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bdaf_pkg::out_t out_data_o
);

  localparam int unsigned FieldMax = 7;
  localparam logic [7:0]  ChZero   = 8'd48;
  localparam logic [7:0]  ChSpace  = 8'd32;
  localparam logic [7:0]  ChMinus  = 8'd45;
  localparam logic [7:0]  ChComma  = 8'd44;

  // tens of a value below 100: x * 205 / 2048
  function automatic logic [3:0] tens_of(input logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic blank);
    return blank ? ChSpace : (ChZero + 8'(d));
  endfunction

  logic             valid_q;
  logic [2:0]       len_q, len_d;
  logic [7:0]       chars_q [FieldMax];
  logic [7:0]       chars_d [FieldMax];
  logic             take;
  logic             load;
  logic [3:0]       d3, d2, d1, d0;
  logic             b4, b3, b2, b1;
  logic [7:0]       c4, c3, c2, c1, c0, cm, cs;

  assign take    = valid_q && !out_stall_i;
  assign ready_o = !valid_q || (take && (len_q == 3'd1));
  assign load    = valid_i && ready_o;

  always_comb begin
    d3 = tens_of(data_i.hl);
    d2 = 4'(data_i.hl - 7'(7'(d3) * 7'd10));
    d1 = tens_of(data_i.lo);
    d0 = 4'(data_i.lo - 7'(7'(d1) * 7'd10));
    // leading-zero blanking, ones digit never blank
    b4 = (data_i.hh == 3'd0);
    b3 = b4 && (data_i.hl < 7'd10);
    b2 = b4 && (data_i.hl == 7'd0);
    b1 = b2 && (data_i.lo < 7'd10);
    c4 = digit_char({1'b0, data_i.hh}, b4);
    c3 = digit_char(d3, b3);
    c2 = digit_char(d2, b2);
    c1 = digit_char(d1, b1);
    c0 = digit_char(d0, 1'b0);
    cm = b3 ? ChSpace : ChComma;
    cs = data_i.neg ? ChMinus : ChSpace;

    for (int i = 0; i < FieldMax; i++) begin
      chars_d[i] = ChSpace;
    end
    len_d = 3'd3;
    case (bdaf_pkg::func_e'(data_i.func))
      bdaf_pkg::FUNC_U8: begin
        chars_d[0] = c2; chars_d[1] = c1; chars_d[2] = c0;
        len_d = 3'd3;
      end
      bdaf_pkg::FUNC_U16: begin
        chars_d[0] = c4; chars_d[1] = c3; chars_d[2] = cm;
        chars_d[3] = c2; chars_d[4] = c1; chars_d[5] = c0;
        len_d = 3'd6;
      end
      bdaf_pkg::FUNC_S8: begin
        chars_d[0] = cs; chars_d[1] = c2; chars_d[2] = c1; chars_d[3] = c0;
        len_d = 3'd4;
      end
      bdaf_pkg::FUNC_S16: begin
        chars_d[0] = cs; chars_d[1] = c4; chars_d[2] = c3; chars_d[3] = cm;
        chars_d[4] = c2; chars_d[5] = c1; chars_d[6] = c0;
        len_d = 3'd7;
      end
      default: begin
        len_d = 3'd3;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      len_q   <= 3'd0;
    end else if (load) begin
      valid_q <= 1'b1;
      len_q   <= len_d;
    end else if (take) begin
      valid_q <= (len_q != 3'd1);
      len_q   <= len_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      chars_q <= chars_d;
    end else if (take) begin
      for (int i = 0; i < FieldMax - 1; i++) begin
        chars_q[i] <= chars_q[i+1];
      end
    end
  end

  assign out_valid_o          = valid_q;
  assign out_data_o.character = chars_q[0];
  assign out_data_o.last      = (len_q == 3'd1);

  `ASSERT_IMPLY(a_len_range, clk_i, rst_ni, valid_q,
                (len_q != 3'd0) && (len_q <= 3'(FieldMax)))
  `ASSERT_NEXT(a_len_step, clk_i, rst_ni, take && (len_q != 3'd1),
               valid_q && (len_q == 3'($past(len_q) - 3'd1)))
  `ASSERT_NEXT(a_load_len, clk_i, rst_ni, load,
               (len_q == 3'd3) || (len_q == 3'd4) || (len_q == 3'd6) || (len_q == 3'd7))

endmodule

### hw/rtl/binary_to_decimal_ascii_formatter_top.sv
// top level of the binary to decimal ascii formatter
//
// input channel: in_valid_i / in_stall_o carry one beat holding a format code
// and a 16-bit value. output channel: out_valid_o / out_stall_i carry one
// ascii character per beat, leftmost first, with last set on the final one.
// field widths: unsigned 8-bit 3, signed 8-bit 4, unsigned 16-bit 6,
// signed 16-bit 7 characters, right-aligned with leading blanks.
// pipeline: input register and hundreds split, digit-pair split, then the
// field register that shifts out one character per beat.
// the first character is offered once the item has passed the input register,
// the digit-pair register and the field register.
// throughput is set by the single-character output port: each item holds it
// for one beat per character of its field. the next field loads on the
// same edge that takes the last character, so fields follow without gaps.
// reset clears all valid flags; nothing is emitted until an item arrives.
// while out_stall_i is high the current character holds and the upstream
// stages fill, after which in_stall_o rises.
module binary_to_decimal_ascii_formatter_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bdaf_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bdaf_pkg::out_t out_data_o
);

  // handshake between stages
  logic             split_ready;
  logic             split_valid;
  bdaf_pkg::split_t split_data;
  logic             hund_ready;
  logic             hund_valid;
  bdaf_pkg::dig_t   hund_data;
  logic             ser_ready;

  assign in_stall_o = !split_ready;

  // magnitude and quotient by one hundred
  bdaf_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (split_ready),
    .data_i  (in_data_i),
    .valid_o (split_valid),
    .ready_i (hund_ready),
    .data_o  (split_data)
  );

  // ten-thousands digit and two pairs below one hundred
  bdaf_hundreds u_hundreds (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (split_valid),
    .ready_o (hund_ready),
    .data_i  (split_data),
    .valid_o (hund_valid),
    .ready_i (ser_ready),
    .data_o  (hund_data)
  );

  // character assembly and one beat per character
  bdaf_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (hund_valid),
    .ready_o     (ser_ready),
    .data_i      (hund_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
